/* hdl/pedd_pkg.sv */
// ----------------------------------------------------------------------------
// pedd_pkg
// Shared types, constants and helpers for the palette dither core.
// ----------------------------------------------------------------------------
package pedd_pkg;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_EOL   = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_SKIP  = 2'd3;

  localparam logic [2:0] REG_COUNT   = 3'd0;
  localparam logic [2:0] REG_PAIR_A  = 3'd1;
  localparam logic [2:0] REG_PAIR_B  = 3'd2;
  localparam logic [2:0] REG_PAIR_C  = 3'd3;
  localparam logic [2:0] REG_LAST    = 3'd4;
  localparam logic [2:0] REG_WEIGHTS = 3'd5;
  localparam logic [2:0] REG_SHAPE   = 3'd6;
  localparam logic [2:0] REG_DIVISOR = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] column;
    logic [11:0] line_width;
  } item_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_ADD, ST_SEARCH, ST_ERR,
    ST_TAP, ST_TAPRD, ST_DIV, ST_TAPWR, ST_OUT
  } back_state_t;

  function automatic logic [7:0] clamp8(input logic signed [17:0] v);
    if (v < 0) return 8'd0;
    else if (v > 18'sd255) return 8'd255;
    else return v[7:0];
  endfunction

endpackage

/* hdl/pedd_queue.sv */
// ----------------------------------------------------------------------------
// pedd_queue
// Front part: takes items, drops unused codes, queues them for the back part.
// ----------------------------------------------------------------------------
module pedd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pedd_pkg::item_t in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output pedd_pkg::item_t q_item
);
  import pedd_pkg::*;

  item_t      slots [2];
  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  logic       push;
  logic       pop;
  logic       keep;

  assign in_ready = (count != 2'd2);
  assign keep     = (in_item.req_type != REQ_SKIP);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slots[wptr] <= in_item;
  end
endmodule

/* hdl/pedd_engine.sv */
// ----------------------------------------------------------------------------
// pedd_engine
// Back part: error stores, palette search and kernel spreading.
// ----------------------------------------------------------------------------
module pedd_engine #(
  parameter int MAX_WIDTH = 2048,
  parameter int ROW_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  pedd_pkg::item_t q_item,
  input  logic [2:0]      palette_count,
  input  logic [167:0]    palette,
  input  logic [59:0]     kernel_weights,
  input  logic [7:0]      kernel_shape,
  input  logic [6:0]      kernel_divisor,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      palette_index
);
  import pedd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int AW = CW + RW;
  localparam int DEPTH = ROW_COUNT * (1 << CW);

  logic [15:0] mem_r [DEPTH];
  logic [15:0] mem_g [DEPTH];
  logic [15:0] mem_b [DEPTH];
  logic [15:0] rd_r, rd_g, rd_b;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [15:0]   wd_r, wd_g, wd_b;

  back_state_t state, state_next;
  logic [AW:0]    clr_cnt;
  logic [RW-1:0]  row_pointer;
  item_t          cur;
  logic [7:0]     cr, cg, cb;
  logic [2:0]     n, best;
  logic [17:0]    best_d;
  logic signed [8:0] er, eg, eb;
  logic [2:0]     kx;
  logic [1:0]     ky;
  logic signed [12:0] pr, pg, pb;
  logic signed [12:0] qr, qg, qb;
  logic [2:0]     div_ch;
  logic [3:0]     div_cnt;
  logic [12:0]    rem, quo;

  logic in_store;
  assign in_store = ({2'b0, cur.column} < 13'(MAX_WIDTH));

  // read/write ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wd_r;
      mem_g[waddr] <= wd_g;
      mem_b[waddr] <= wd_b;
    end
    rd_r <= mem_r[raddr];
    rd_g <= mem_g[raddr];
    rd_b <= mem_b[raddr];
  end

  // kernel decode
  logic [2:0] kw, ox;
  logic [1:0] kh;
  logic [6:0] dv;
  logic [12:0] lw;
  logic signed [13:0] tx;
  logic [RW-1:0] trow;
  logic [3:0] wj, wt;
  logic tap_ok;
  logic last_tap;
  logic [2:0] rowsum;
  assign kw = (kernel_shape[2:0] > 3'd5) ? 3'd5 : kernel_shape[2:0];
  assign kh = kernel_shape[4:3];
  assign ox = kernel_shape[7:5];
  assign dv = (kernel_divisor == 7'd0) ? 7'd1 : kernel_divisor;
  assign lw = ({1'b0, cur.line_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
              : {1'b0, cur.line_width};
  assign tx = 14'(signed'({3'b0, cur.column})) + 14'(kx) - 14'(ox);
  assign rowsum = 3'(row_pointer) + 3'(ky);
  assign trow = RW'((rowsum >= 3'(ROW_COUNT)) ? rowsum - 3'(ROW_COUNT) : rowsum);
  assign wj = 4'(ky * kw) + 4'(kx);
  assign wt = kernel_weights[wj*4 +: 4];
  assign tap_ok = (tx >= 0) && (tx < 14'(lw)) && (wt != 4'd0);
  assign last_tap = (kx == kw - 3'd1) && (ky == kh - 2'd1);

  // palette search
  logic [23:0] ent, bent;
  logic signed [8:0] dr, dg, db;
  logic [17:0] sq_dist;
  logic [2:0] cnt;
  assign ent = palette[n*24 +: 24];
  assign bent = palette[best*24 +: 24];
  assign dr = 9'(cr) - 9'(ent[23:16]);
  assign dg = 9'(cg) - 9'(ent[15:8]);
  assign db = 9'(cb) - 9'(ent[7:0]);
  assign sq_dist = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
  assign cnt = (palette_count < 3'd1) ? 3'd1 : palette_count;

  // signed tap product magnitude
  logic signed [12:0] prod;
  logic [12:0] mag;
  assign prod = (div_ch == 3'd0) ? pr : (div_ch == 3'd1) ? pg : pb;
  assign mag = prod[12] ? 13'(-prod) : prod;
  logic [13:0] rtrial;
  assign rtrial = {rem, mag[4'd12 - div_cnt]} - 14'(dv);

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    we = 1'b0;
    waddr = {trow, tx[CW-1:0]};
    raddr = {trow, tx[CW-1:0]};
    wd_r = rd_r + 16'(qr);
    wd_g = rd_g + 16'(qg);
    wd_b = rd_b + 16'(qb);
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_cnt[AW-1:0];
        wd_r = '0; wd_g = '0; wd_b = '0;
        if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.req_type == REQ_START) state_next = ST_CLEAR;
          else if (q_item.req_type == REQ_PIXEL) state_next = ST_READ;
        end
      end
      ST_READ: begin
        raddr = {row_pointer, CW'(cur.column)};
        state_next = ST_ADD;
      end
      ST_ADD: begin
        we = in_store;
        waddr = {row_pointer, CW'(cur.column)};
        wd_r = '0; wd_g = '0; wd_b = '0;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: if (n == cnt - 3'd1 || n == 3'd6) state_next = ST_ERR;
      ST_ERR: state_next = (in_store && kh != 0 && kw != 0) ? ST_TAP : ST_OUT;
      ST_TAP: begin
        if (tap_ok) state_next = ST_TAPRD;
        else if (last_tap) state_next = ST_OUT;
      end
      ST_TAPRD: state_next = ST_DIV;
      ST_DIV: if (div_cnt == 4'd12 && div_ch == 3'd2) state_next = ST_TAPWR;
      ST_TAPWR: begin
        we = 1'b1;
        state_next = last_tap ? ST_OUT : ST_TAP;
      end
      ST_OUT: if (out_ready || !out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      row_pointer <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && (out_ready || !out_valid)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      state <= state_next;
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: if (q_valid) begin
          cur <= q_item;
          clr_cnt <= '0;
          if (q_item.req_type == REQ_EOL)
            row_pointer <= (row_pointer == RW'(ROW_COUNT - 1)) ? '0
                           : row_pointer + 1'b1;
          if (q_item.req_type == REQ_START) row_pointer <= '0;
        end
        ST_ADD: begin
          cr <= clamp8(18'(signed'({1'b0, cur.red}))
                + (in_store ? 18'(signed'(rd_r)) : 18'sd0));
          cg <= clamp8(18'(signed'({1'b0, cur.green}))
                + (in_store ? 18'(signed'(rd_g)) : 18'sd0));
          cb <= clamp8(18'(signed'({1'b0, cur.blue}))
                + (in_store ? 18'(signed'(rd_b)) : 18'sd0));
          n <= 3'd0;
          best_d <= '1;
          best <= 3'd0;
        end
        ST_SEARCH: begin
          if (n == 3'd0 || sq_dist < best_d) begin
            best_d <= sq_dist;
            best <= n;
          end
          n <= n + 3'd1;
        end
        ST_ERR: begin
          n <= best;
          kx <= 3'd0;
          ky <= 2'd0;
          er <= 9'(cr) - 9'(bent[23:16]);
          eg <= 9'(cg) - 9'(bent[15:8]);
          eb <= 9'(cb) - 9'(bent[7:0]);
        end
        ST_TAP: begin
          if (tap_ok) begin
            pr <= 13'(er * $signed({1'b0, wt}));
            pg <= 13'(eg * $signed({1'b0, wt}));
            pb <= 13'(eb * $signed({1'b0, wt}));
            div_ch <= 3'd0;
            div_cnt <= 4'd0;
            rem <= '0;
          end else begin
            if (kx == kw - 3'd1) begin
              kx <= 3'd0;
              ky <= ky + 2'd1;
            end else kx <= kx + 3'd1;
          end
        end
        ST_DIV: begin
          quo <= {quo[11:0], !rtrial[13]};
          if (div_cnt == 4'd12) begin
            div_cnt <= 4'd0;
            rem <= '0;
            div_ch <= div_ch + 3'd1;
            unique case (div_ch)
              3'd0: qr <= prod[12] ? -{quo[11:0], !rtrial[13]}
                                   : {quo[11:0], !rtrial[13]};
              3'd1: qg <= prod[12] ? -{quo[11:0], !rtrial[13]}
                                   : {quo[11:0], !rtrial[13]};
              default: qb <= prod[12] ? -{quo[11:0], !rtrial[13]}
                                      : {quo[11:0], !rtrial[13]};
            endcase
          end else begin
            div_cnt <= div_cnt + 4'd1;
            if (!rtrial[13]) rem <= rtrial[12:0];
            else rem <= {rem[11:0], mag[4'd12 - div_cnt]};
          end
        end
        ST_TAPWR: begin
          if (kx == kw - 3'd1) begin
            kx <= 3'd0;
            ky <= ky + 2'd1;
          end else kx <= kx + 3'd1;
        end
        ST_OUT: if (out_ready || !out_valid) palette_index <= best;
        default: ;
      endcase
    end
  end
endmodule

/* hdl/palette_error_diffusion_dither_core.sv */
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_core
// Error-diffusion dither of RGB pixels onto a palette of up to seven colors.
// ----------------------------------------------------------------------------
// per pixel: palette search, then a kernel walk with a divide per used tap
// throughput: one item at a time, set by the shared bit-serial tap divider
// after reset a clearing pass over every store entry (8192 at default sizes)
// zeroes the stores; a start item runs the same pass
module palette_error_diffusion_dither_core #(
  parameter int MAX_WIDTH = 2048,
  parameter int ROW_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [10:0] column,
  input  logic [11:0] line_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  palette_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import pedd_pkg::*;

  logic [2:0]  palette_count;
  logic [47:0] pair_a, pair_b, pair_c;
  logic [23:0] pal_last;
  logic [59:0] weights;
  logic [7:0]  shape;
  logic [6:0]  divisor;
  item_t in_item, q_item;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  assign in_item = '{req_type, red, green, blue, column, line_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= 3'd3;
      pair_a <= 48'hFFFFFF;
      pair_b <= 48'hFF0000;
      pair_c <= '0;
      pal_last <= '0;
      weights <= 60'h153700;
      shape <= 8'd51;
      divisor <= 7'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COUNT:   palette_count <= cfg_data[2:0];
        REG_PAIR_A:  pair_a <= cfg_data[47:0];
        REG_PAIR_B:  pair_b <= cfg_data[47:0];
        REG_PAIR_C:  pair_c <= cfg_data[47:0];
        REG_LAST:    pal_last <= cfg_data[23:0];
        REG_WEIGHTS: weights <= cfg_data;
        REG_SHAPE:   shape <= cfg_data[7:0];
        REG_DIVISOR: divisor <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  pedd_queue u_queue (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  pedd_engine #(.MAX_WIDTH(MAX_WIDTH), .ROW_COUNT(ROW_COUNT)) u_engine (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .palette_count,
    .palette({pal_last, pair_c, pair_b, pair_a}),
    .kernel_weights(weights), .kernel_shape(shape), .kernel_divisor(divisor),
    .out_valid, .out_ready, .palette_index
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(palette_index))
    else $error("result dropped under stall");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> palette_index != 3'd7)
    else $error("palette index out of range");
endmodule

/* bench/palette_error_diffusion_dither_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_checker
// Watches the pixel, result and register channels of the dither core, keeps
// its own palette, kernel and error row stores, predicts the palette index of
// every accepted pixel and compares it with the results in order.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [10:0] column,
  input  logic [11:0] line_width,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  palette_index,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,
  output int          errors,
  output int          pending
);
  import pedd_pkg::*;

  localparam int LINE_MAX = 2048;
  localparam int RING = 4;

  logic [2:0]  pal_count;
  logic [47:0] pal_a, pal_b, pal_c;
  logic [23:0] pal_last;
  logic [59:0] k_weights;
  logic [7:0]  k_shape;
  logic [6:0]  k_divisor;

  logic [15:0] resid_red[0:RING*LINE_MAX-1];
  logic [15:0] resid_green[0:RING*LINE_MAX-1];
  logic [15:0] resid_blue[0:RING*LINE_MAX-1];
  int          ring_row;
  logic [2:0]  index_q[$];

  initial errors = 0;
  initial pending = 0;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [23:0] entry_rgb(input int n);
    case (n)
      0: return pal_a[23:0];
      1: return pal_a[47:24];
      2: return pal_b[23:0];
      3: return pal_b[47:24];
      4: return pal_c[23:0];
      5: return pal_c[47:24];
      default: return pal_last;
    endcase
  endfunction

  function automatic void clear_resid();
    for (int i = 0; i < RING*LINE_MAX; i++) begin
      resid_red[i] = '0;
      resid_green[i] = '0;
      resid_blue[i] = '0;
    end
    ring_row = 0;
  endfunction

  function automatic logic [2:0] dither_pixel();
    int r, g, b, col, lw, a, cnt, best, best_d, d, dr, dg, db;
    int er, eg, eb, kw, kh, ox, dv, row, x, j, w, q;
    logic [23:0] e;
    r = red;
    g = green;
    b = blue;
    col = column;
    lw = (line_width > LINE_MAX) ? LINE_MAX : line_width;
    a = ring_row * LINE_MAX + col;
    r += int'($signed(resid_red[a]));
    g += int'($signed(resid_green[a]));
    b += int'($signed(resid_blue[a]));
    resid_red[a] = '0;
    resid_green[a] = '0;
    resid_blue[a] = '0;
    r = (r < 0) ? 0 : (r > 255) ? 255 : r;
    g = (g < 0) ? 0 : (g > 255) ? 255 : g;
    b = (b < 0) ? 0 : (b > 255) ? 255 : b;
    cnt = (pal_count < 1) ? 1 : pal_count;
    best = 0;
    best_d = 32'h7fffffff;
    for (int n = 0; n < cnt; n++) begin
      e = entry_rgb(n);
      dr = r - e[23:16];
      dg = g - e[15:8];
      db = b - e[7:0];
      d = dr*dr + dg*dg + db*db;
      if (d < best_d) begin
        best_d = d;
        best = n;
      end
    end
    e = entry_rgb(best);
    er = r - e[23:16];
    eg = g - e[15:8];
    eb = b - e[7:0];
    kw = k_shape[2:0];
    if (kw > 5) kw = 5;
    kh = k_shape[4:3];
    ox = k_shape[7:5];
    dv = (k_divisor == 0) ? 1 : k_divisor;
    for (int ky = 0; ky < kh; ky++) begin
      row = (ring_row + ky) % RING;
      for (int kx = 0; kx < kw; kx++) begin
        x = col + kx - ox;
        j = ky * kw + kx;
        w = int'((k_weights >> (4*j)) & 60'hf);
        if (x >= 0 && x < lw && w != 0) begin
          a = row * LINE_MAX + x;
          q = (w * er) / dv;
          resid_red[a] = resid_red[a] + q[15:0];
          q = (w * eg) / dv;
          resid_green[a] = resid_green[a] + q[15:0];
          q = (w * eb) / dv;
          resid_blue[a] = resid_blue[a] + q[15:0];
        end
      end
    end
    return best[2:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [2:0] want;
    if (rst) begin
      pal_count = 3'd3;
      pal_a = 48'hffffff;
      pal_b = 48'hff0000;
      pal_c = '0;
      pal_last = '0;
      k_weights = 60'h153700;
      k_shape = 8'd51;
      k_divisor = 7'd16;
      clear_resid();
      index_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (index_q.size() == 0) begin
          report($sformatf("palette_index %0d with no item waiting", palette_index));
        end else begin
          want = index_q.pop_front();
          if (palette_index !== want)
            report($sformatf("palette_index %0d, want %0d", palette_index, want));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COUNT:   pal_count = cfg_data[2:0];
          REG_PAIR_A:  pal_a = cfg_data[47:0];
          REG_PAIR_B:  pal_b = cfg_data[47:0];
          REG_PAIR_C:  pal_c = cfg_data[47:0];
          REG_LAST:    pal_last = cfg_data[23:0];
          REG_WEIGHTS: k_weights = cfg_data;
          REG_SHAPE:   k_shape = cfg_data[7:0];
          REG_DIVISOR: k_divisor = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (req_type)
          REQ_PIXEL: index_q.push_back(dither_pixel());
          REQ_EOL:   ring_row = (ring_row + 1) % RING;
          REQ_START: clear_resid();
          default: ;
        endcase
      end
    end
    pending <= index_q.size();
  end

endmodule

/* bench/palette_error_diffusion_dither_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_core_tb
// Drives directed and row-structured random pixel streams through the dither
// core under a series of palette and kernel settings and idling patterns;
// the checker predicts every palette index and counts mismatches.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_core_tb;
  import pedd_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_PIXEL;
  logic [7:0]  red = '0, green = '0, blue = '0;
  logic [10:0] column = '0;
  logic [11:0] line_width = 12'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  palette_index;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_COUNT;
  logic [59:0] cfg_data = '0;
  int          errors, pending;
  int          send_idle = 18, recv_idle = 67;
  int          quiet = 0;
  bit          cleared_since = 1'b1;

  always #1 clk = ~clk;

  palette_error_diffusion_dither_core DUT (.*);

  palette_error_diffusion_dither_checker chk (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("palette_error_diffusion_dither_core_tb: done, errors");
      $finish;
    end
  end

  task automatic send(input logic [1:0] t, input logic [7:0] r, g, b,
                      input int col, input int lw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= t;
    red <= r;
    green <= g;
    blue <= b;
    column <= col[10:0];
    line_width <= lw[11:0];
    if (t == REQ_START) cleared_since = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (cleared_since ? 9000 : 300) @(negedge clk);
    cleared_since = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [59:0] rand60();
    return 60'({$urandom, $urandom});
  endfunction

  function automatic logic [7:0] shade();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic program_setting(input int s);
    logic [59:0] v[8];
    for (int i = 0; i < 8; i++) v[i] = rand60();
    case (s % 5)
      1: begin
        v[0] = 60'd0; v[5] = '1; v[6] = 60'hff; v[7] = 60'd0;
      end
      2: begin
        v[0] = 60'd1; v[5] = '0; v[6] = 60'h00; v[7] = 60'd127;
      end
      3: begin
        v[0] = 60'd7; v[1] = '0; v[2] = '1; v[3] = '0; v[4] = '1;
        v[5] = '1; v[6] = 60'({3'd5, 2'd3, 3'd3}); v[7] = 60'd1;
      end
      4: begin
        v[0] = 60'd2; v[6] = 60'({3'd0, 2'd3, 3'd5});
        v[7] = 60'($urandom_range(1, 127));
      end
      default: ;
    endcase
    write_reg(REG_COUNT, v[0]);
    write_reg(REG_PAIR_A, v[1]);
    write_reg(REG_PAIR_B, v[2]);
    write_reg(REG_PAIR_C, v[3]);
    write_reg(REG_LAST, v[4]);
    write_reg(REG_WEIGHTS, v[5]);
    write_reg(REG_SHAPE, v[6]);
    write_reg(REG_DIVISOR, v[7]);
  endtask

  task automatic random_rows(input int budget);
    int sent, lw;
    sent = 0;
    while (sent < budget) begin
      lw = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      for (int c = 0; c < lw && sent < budget; c++) begin
        if ($urandom_range(19) == 0) begin
          send($urandom_range(3) == 3 ? REQ_SKIP : REQ_PIXEL,
               8'($urandom), 8'($urandom), 8'($urandom),
               $urandom_range(2047), $urandom_range(4095));
          sent++;
        end
        send(REQ_PIXEL, shade(), shade(), shade(), c, lw);
        sent++;
        if (sent == budget / 2 && $urandom_range(3) == 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
      if ($urandom_range(14) != 0) send(REQ_EOL, 8'd0, 8'd0, 8'd0, 0, 1);
      if ($urandom_range(39) == 0) send(REQ_START, 8'd0, 8'd0, 8'd0, 0, 1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 0, 1);
    send(REQ_PIXEL, 8'hff, 8'hff, 8'hff, 0, 2048);
    send(REQ_PIXEL, 8'hff, 8'h00, 8'h00, 1, 2048);
    send(REQ_PIXEL, 8'h80, 8'h80, 8'h80, 2, 2048);
    send(REQ_PIXEL, 8'h7f, 8'h7f, 8'h7f, 3, 4095);
    send(REQ_PIXEL, 8'haa, 8'h55, 8'hcc, 2047, 4095);
    send(REQ_PIXEL, 8'h55, 8'haa, 8'h33, 2047, 2048);
    send(REQ_SKIP, 8'hff, 8'hff, 8'hff, 5, 8);
    send(REQ_EOL, 8'd0, 8'd0, 8'd0, 0, 1);
    send(REQ_PIXEL, 8'h40, 8'h80, 8'hc0, 0, 3);
    send(REQ_PIXEL, 8'h40, 8'h80, 8'hc0, 1, 3);
    send(REQ_PIXEL, 8'h40, 8'h80, 8'hc0, 2, 3);
    send(REQ_EOL, 8'd0, 8'd0, 8'd0, 0, 1);
    send(REQ_PIXEL, 8'h10, 8'hf0, 8'h10, 1, 3);
    send(REQ_EOL, 8'd0, 8'd0, 8'd0, 0, 1);
    send(REQ_EOL, 8'd0, 8'd0, 8'd0, 0, 1);
    send(REQ_EOL, 8'd0, 8'd0, 8'd0, 0, 1);
    send(REQ_PIXEL, 8'h20, 8'h20, 8'h20, 0, 3);
    send(REQ_START, 8'd0, 8'd0, 8'd0, 0, 1);
    send(REQ_PIXEL, 8'h90, 8'h90, 8'h90, 0, 2);
    send(REQ_PIXEL, 8'h90, 8'h90, 8'h90, 1, 2);
    drain();

    for (int s = 0; s < 9; s++) begin
      case (s / 3)
        0: begin send_idle = 18; recv_idle = 67; end
        1: begin send_idle = 67; recv_idle = 18; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      program_setting(s);
      random_rows(200);
      drain();
    end

    if (errors == 0)
      $display("palette_error_diffusion_dither_core_tb: done, clean");
    else
      $display("palette_error_diffusion_dither_core_tb: done, errors");
    $finish;
  end

endmodule

/* palette_error_diffusion_dither_core.f */
hdl/pedd_pkg.sv
hdl/pedd_queue.sv
hdl/pedd_engine.sv
hdl/palette_error_diffusion_dither_core.sv
bench/palette_error_diffusion_dither_checker.sv
bench/palette_error_diffusion_dither_core_tb.sv
